// File: hdl/deq_pkg.sv
// deq_pkg: command and status codes and fixed field widths of the deque unit.
// No dependencies; imported by the interfaces, the top level and the checker.
package deq_pkg;

  localparam int CMD_BITS   = 3;
  localparam int WORD_W     = 32;
  localparam int POS_BITS   = 8;
  localparam int ENT_BITS   = 9;
  localparam int STAT_BITS  = 2;

  localparam logic [CMD_BITS-1:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_POP_BACK   = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_PUSH_FRONT = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_READ_IDX   = 3'd4;

  localparam logic [STAT_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_BITS-1:0] ST_RANGE = 2'd3;

  typedef logic [CMD_BITS-1:0]  cmd_t;
  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [POS_BITS-1:0]  pos_t;
  typedef logic [ENT_BITS-1:0]  ent_t;
  typedef logic [STAT_BITS-1:0] stat_t;

endpackage

// File: hdl/deq_if.sv
// deq_in_if / deq_out_if: valid/ready channels of the deque unit.
// Depends on deq_pkg for payload types.
interface deq_in_if
  import deq_pkg::*;
  ();
  logic  valid;
  logic  ready;
  cmd_t  cmd;
  word_t word_in;
  pos_t  position;

  modport source (output valid, output cmd, output word_in, output position, input ready);
  modport sink   (input valid, input cmd, input word_in, input position, output ready);
endinterface

interface deq_out_if
  import deq_pkg::*;
  ();
  logic  valid;
  logic  ready;
  word_t word_out;
  stat_t status;
  ent_t  entries;

  modport source (output valid, output word_out, output status, output entries, input ready);
  modport sink   (input valid, input word_out, input status, input entries, output ready);
endinterface

// File: hdl/deq_ram.sv
// deq_ram: single-port ring store with registered read data.
// No package dependency; instantiated by double_ended_queue_unit.
module deq_ram #(
  parameter int DEPTH     = 256,
  parameter int WORD_BITS = 32,
  localparam int AW       = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic                 we,
  input  logic [AW-1:0]        addr,
  input  logic [WORD_BITS-1:0] wdata,
  output logic [WORD_BITS-1:0] rdata
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: hdl/double_ended_queue_unit.sv
// double_ended_queue_unit: bounded deque of words in a ring store, one result per command.
// Depends on deq_pkg, deq_in_if / deq_out_if and deq_ram.
//
//  channel  | direction | handshake     | word carries
//  ---------+-----------+---------------+------------------------------
//  in_ch    | in        | valid / ready | cmd, word_in, position
//  out_ch   | out       | valid / ready | word_out, status, entries
//
// Sustained rate is one word per cycle while out_ch keeps taking results. out_ch.valid
// rises when the result moves from the pending stage to the output register; the read
// data comes from the registered read port of the ring store.
// A command's memory access and pointer update happen at its accept edge; the
// result waits in a pending stage, then moves to the output register.
// Reset (rst_n low, synchronous) empties the queue; the store is not cleared.
// When the output register is stalled, one further word is taken into the
// pending stage and in_ch.ready then drops until out_ch moves.
module double_ended_queue_unit
  import deq_pkg::*;
#(
  parameter int DEPTH     = 256,
  parameter int WORD_BITS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  deq_in_if.sink   in_ch,
  deq_out_if.source out_ch
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_BITS) ? CW : POS_BITS;

  // queue state
  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // pending stage: command accepted, read data arriving from the store
  logic          pend_r;
  logic          pend_rd_r;
  stat_t         pend_st_r;
  ent_t          pend_ent_r;

  // output register
  logic          out_valid_r;
  word_t         out_word_r;
  stat_t         out_st_r;
  ent_t          out_ent_r;

  logic                 acc;
  logic                 out_free;
  logic                 full;
  logic                 empty;
  logic                 ram_en;
  logic                 ram_we;
  logic [AW-1:0]        ram_addr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [AW:0]          offset;
  logic [AW:0]          ring_sum;
  logic [AW-1:0]        ring_idx;
  logic [AW-1:0]        front_dec;
  logic                 rd_flag;
  stat_t                st;
  logic [63:0]          win_ext;
  logic [63:0]          rd_ext;

  assign out_free    = !out_valid_r || out_ch.ready;
  // pending word can leave this cycle, so a new one may enter
  assign in_ch.ready = !pend_r || out_free;
  assign acc         = in_ch.valid && in_ch.ready;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  // store width follows WORD_BITS; ports keep the fixed 32-bit field
  assign win_ext   = 64'(in_ch.word_in);
  assign ram_wdata = win_ext[WORD_BITS-1:0];

  // slot before the front, wrapping at the bottom of the ring
  assign front_dec = (front_r == '0) ? AW'(DEPTH - 1) : (front_r - AW'(1));

  // front + offset modulo DEPTH; both terms stay below DEPTH whenever the store is accessed
  assign ring_sum = {1'b0, front_r} + offset;
  assign ring_idx = (ring_sum >= (AW + 1)'(DEPTH)) ? AW'(ring_sum - (AW + 1)'(DEPTH))
                                                   : ring_sum[AW-1:0];

  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    offset    = '0;
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = ring_idx;
    rd_flag   = 1'b0;
    st        = ST_OK;
    case (in_ch.cmd)
      CMD_PUSH_BACK: begin
        offset = (AW + 1)'(count_r);
        if (full) begin
          st = ST_FULL;
        end else begin
          ram_en    = acc;
          ram_we    = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      CMD_POP_BACK: begin
        offset = (AW + 1)'(count_r - CW'(1));
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          ram_en    = acc;
          rd_flag   = 1'b1;
          count_nxt = count_r - CW'(1);
        end
      end
      CMD_PUSH_FRONT: begin
        ram_addr = front_dec;
        if (full) begin
          st = ST_FULL;
        end else begin
          ram_en    = acc;
          ram_we    = 1'b1;
          front_nxt = front_dec;
          count_nxt = count_r + CW'(1);
        end
      end
      CMD_POP_FRONT: begin
        ram_addr = front_r;
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          ram_en    = acc;
          rd_flag   = 1'b1;
          front_nxt = (front_r == AW'(DEPTH - 1)) ? '0 : (front_r + AW'(1));
          count_nxt = count_r - CW'(1);
        end
      end
      CMD_READ_IDX: begin
        offset = (AW + 1)'(in_ch.position);
        if (CMPW'(in_ch.position) >= CMPW'(count_r)) begin
          st = ST_RANGE;
        end else begin
          ram_en  = acc;
          rd_flag = 1'b1;
        end
      end
      default: begin
        // unknown command: no change, plain status
      end
    endcase
  end

  deq_ram #(
    .DEPTH    (DEPTH),
    .WORD_BITS(WORD_BITS)
  ) u_deq_ram (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // each command touches one slot once, and a write is visible to the next
  // command's read, so no forwarding path is needed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else if (acc) begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (acc) begin
      pend_r <= 1'b1;
    end else if (out_free) begin
      pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pend_rd_r  <= rd_flag;
      pend_st_r  <= st;
      pend_ent_r <= ENT_BITS'(count_nxt);
    end
  end

  assign rd_ext = 64'(ram_rdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && pend_r) begin
      out_word_r <= pend_rd_r ? rd_ext[WORD_W-1:0] : '0;
      out_st_r   <= pend_st_r;
      out_ent_r  <= pend_ent_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.word_out = out_word_r;
  assign out_ch.status   = out_st_r;
  assign out_ch.entries  = out_ent_r;

endmodule

// File: hdl/deq_checker.sv
// deq_checker: port-level assertions on the deque unit's result channel.
// Depends on deq_pkg; bound to double_ended_queue_unit below.
module deq_checker
  import deq_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input logic  clk,
  input logic  rst_n,
  input logic  out_valid,
  input logic  out_ready,
  input word_t out_word,
  input stat_t out_status,
  input ent_t  out_entries
);

  // failed command returns a zero word
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY || out_status == ST_FULL ||
                  out_status == ST_RANGE) |-> out_word == '0)
    else $error("non-zero word with error status");

  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_entries == '0)
    else $error("empty status with entries");

  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_entries == ENT_BITS'(DEPTH))
    else $error("full status without full count");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word) &&
                                $stable(out_status) && $stable(out_entries))
    else $error("stalled result word changed");

endmodule

bind double_ended_queue_unit deq_checker #(
  .DEPTH(DEPTH)
) u_deq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_word   (out_ch.word_out),
  .out_status (out_ch.status),
  .out_entries(out_ch.entries)
);

// File: dv/double_ended_queue_unit_tb.sv
`timescale 1ns / 100ps
// double_ended_queue_unit_tb: self-checking bench for the deque unit, with its own deque model.
// Depends on deq_pkg, deq_in_if / deq_out_if and double_ended_queue_unit from hdl.

module double_ended_queue_unit_tb;
  import deq_pkg::*;

  localparam int RING_SLOTS   = 256;        // default DEPTH of the unit
  localparam int HOLD_CYCLES  = 60;         // long receiver back-pressure stretch
  localparam int RUN_LIMIT_NS = 5_000_000;  // far beyond the slowest legal run

  // one command word as offered on in_ch, one result word as seen on out_ch
  typedef struct packed {
    cmd_t  op;
    word_t data;
    pos_t  idx;
  } cmd_word_t;

  typedef struct packed {
    word_t data;
    stat_t code;
    ent_t  fill;
  } result_word_t;

  logic clk;
  logic rst_n;

  deq_in_if  in_ch ();
  deq_out_if out_ch ();

  double_ended_queue_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Deque model: ring of words, slot of the front entry and entry count.
  // Only slots that were written are ever read, so the ring needs no clearing.
  // ---------------------------------------------------------------------------
  word_t        ring_store [RING_SLOTS];
  logic [7:0]   head_slot  = '0;
  ent_t         fill_level = '0;

  result_word_t expected_q [$];   // results still owed by the unit, oldest first
  cmd_word_t    pending_q  [$];   // command words not yet offered

  int gen_fill     = 0;           // entry count as the generator sees it
  int err_count    = 0;
  int results_seen = 0;
  bit hold_off;

  // Applies one accepted command to the model and returns the result it owes.
  function automatic result_word_t deque_apply(cmd_word_t w);
    result_word_t r;
    logic [7:0]   slot;
    r.data = '0;
    r.code = ST_OK;
    case (w.op)
      CMD_PUSH_BACK: begin
        if (fill_level == RING_SLOTS) begin
          r.code = ST_FULL;
        end else begin
          slot = head_slot + fill_level[7:0];
          ring_store[slot] = w.data;
          fill_level++;
        end
      end
      CMD_POP_BACK: begin
        if (fill_level == 0) begin
          r.code = ST_EMPTY;
        end else begin
          // at 256 entries the low byte wraps to 0, so head - 1 is still the back
          slot = head_slot + fill_level[7:0] - 8'd1;
          r.data = ring_store[slot];
          fill_level--;
        end
      end
      CMD_PUSH_FRONT: begin
        if (fill_level == RING_SLOTS) begin
          r.code = ST_FULL;
        end else begin
          head_slot = head_slot - 8'd1;
          ring_store[head_slot] = w.data;
          fill_level++;
        end
      end
      CMD_POP_FRONT: begin
        if (fill_level == 0) begin
          r.code = ST_EMPTY;
        end else begin
          r.data = ring_store[head_slot];
          head_slot = head_slot + 8'd1;
          fill_level--;
        end
      end
      CMD_READ_IDX: begin
        // includes index 0 on an empty queue
        if ({1'b0, w.idx} >= fill_level) begin
          r.code = ST_RANGE;
        end else begin
          slot = head_slot + w.idx;
          r.data = ring_store[slot];
        end
      end
      default: begin
        // unused codes leave everything alone and report ok
      end
    endcase
    r.fill = fill_level;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    err_count++;
    $display("[%0t] deque check: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus generation. The generator tracks the entry count itself so that
  // it can steer the queue to full and back to empty.
  // ---------------------------------------------------------------------------
  task automatic queue_cmd(cmd_t op, word_t data, pos_t idx);
    cmd_word_t w;
    w.op   = op;
    w.data = data;
    w.idx  = idx;
    pending_q.push_back(w);
    case (op)
      CMD_PUSH_BACK, CMD_PUSH_FRONT: if (gen_fill < RING_SLOTS) gen_fill++;
      CMD_POP_BACK, CMD_POP_FRONT:   if (gen_fill > 0) gen_fill--;
      default: ;
    endcase
  endtask

  function automatic word_t rand_data();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return word_t'($urandom());
    endcase
  endfunction

  // push_pct: chance of a push; the rest is mostly pops, some reads, a few
  // unused codes
  task automatic queue_random(int push_pct);
    int   roll;
    cmd_t op;
    pos_t idx;
    roll = $urandom_range(0, 99);
    idx  = pos_t'($urandom_range(0, 255));
    if (roll < push_pct) begin
      op = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        op = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
      end else if (roll < 95) begin
        op = CMD_READ_IDX;
        case ($urandom_range(0, 4))
          0, 1, 2: if (gen_fill > 0) idx = pos_t'($urandom_range(0, gen_fill - 1));
          3:       idx = gen_fill[7:0];   // just past the end, unless full
          default: ;
        endcase
      end else begin
        op = cmd_t'($urandom_range(5, 7));
      end
    end
    queue_cmd(op, rand_data(), idx);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers pending command words, with a drawn gap after each one.
  // Idle gaps are switched off for whole stretches now and then.
  // ---------------------------------------------------------------------------
  cmd_word_t next_word;
  int        in_gap  = 0;
  int        in_sent = 0;
  bit        in_calm = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        next_word.op   = in_ch.cmd;
        next_word.data = in_ch.word_in;
        next_word.idx  = in_ch.position;
        expected_q.push_back(deque_apply(next_word));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          next_word = pending_q.pop_front();
          in_ch.cmd      <= next_word.op;
          in_ch.word_in  <= next_word.data;
          in_ch.position <= next_word.idx;
          in_ch.valid    <= 1'b1;
          in_sent++;
          if (in_sent % 40 == 0) in_calm = ($urandom_range(0, 2) == 0);
          in_gap = in_calm ? 0 : $urandom_range(0, 3);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: takes result words with its own random stalls and compares each
  // against the oldest outstanding expectation.
  // ---------------------------------------------------------------------------
  result_word_t want;
  int           out_wait = 0;
  bit           out_calm = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          report_mismatch("result word with nothing outstanding");
        end else begin
          want = expected_q.pop_front();
          if (out_ch.word_out !== want.data)
            report_mismatch($sformatf("word_out %h, want %h", out_ch.word_out, want.data));
          if (out_ch.status !== want.code)
            report_mismatch($sformatf("status %0d, want %0d", out_ch.status, want.code));
          if (out_ch.entries !== want.fill)
            report_mismatch($sformatf("entries %0d, want %0d", out_ch.entries, want.fill));
        end
        if (results_seen % 40 == 0) out_calm = ($urandom_range(0, 2) == 0);
        out_wait = out_calm ? 0 : $urandom_range(0, 3);
      end
      if (hold_off) begin
        out_ch.ready <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Long back-pressure: the sender keeps offering so the unit fills its
  // output and pending stages and drops in_ch.ready.
  initial begin
    hold_off = 1'b0;
    while (results_seen < 40) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("double_ended_queue_unit: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed corner cases, then a fill to full, a drain
  // to empty and a short mixed stretch.
  // ---------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.cmd      = CMD_PUSH_BACK;
    in_ch.word_in  = '0;
    in_ch.position = '0;
    out_ch.ready   = 1'b0;

    // pops and reads on an empty queue
    queue_cmd(CMD_POP_BACK,  32'h1234_5678, 8'h00);
    queue_cmd(CMD_POP_FRONT, 32'h8765_4321, 8'h00);
    queue_cmd(CMD_READ_IDX,  '0,            8'h00);
    queue_cmd(CMD_READ_IDX,  '1,            8'hff);
    // both ends, extreme words
    queue_cmd(CMD_PUSH_BACK,  '0,            8'hff);
    queue_cmd(CMD_PUSH_FRONT, '1,            8'h00);
    queue_cmd(CMD_PUSH_BACK,  32'ha5a5_a5a5, 8'h00);
    queue_cmd(CMD_PUSH_FRONT, 32'h5a5a_5a5a, 8'h00);
    // reads in range, just past the end, and far past it
    queue_cmd(CMD_READ_IDX, '0, 8'h00);
    queue_cmd(CMD_READ_IDX, '0, 8'h03);
    queue_cmd(CMD_READ_IDX, '0, 8'h04);
    queue_cmd(CMD_READ_IDX, '0, 8'hff);
    // unused codes change nothing
    queue_cmd(cmd_t'(5), '1, 8'hff);
    queue_cmd(cmd_t'(6), '0, 8'h00);
    queue_cmd(cmd_t'(7), '1, 8'h55);
    // drain through both ends, then one pop too many
    queue_cmd(CMD_POP_FRONT, '0, 8'h00);
    queue_cmd(CMD_POP_BACK,  '0, 8'h00);
    queue_cmd(CMD_POP_FRONT, '0, 8'h00);
    queue_cmd(CMD_POP_BACK,  '0, 8'h00);
    queue_cmd(CMD_POP_BACK,  '0, 8'h00);

    // push-heavy to full, pushes against full, reads across a full ring
    while (gen_fill < RING_SLOTS) queue_random(95);
    repeat (6) queue_random(100);
    queue_cmd(CMD_READ_IDX, '0, 8'hff);
    queue_cmd(CMD_READ_IDX, '0, 8'h00);
    repeat (20) queue_random(30);
    // pop-heavy to empty, then pops and reads against empty
    while (gen_fill > 0) queue_random(0);
    repeat (6) queue_random(0);
    repeat (60) queue_random(50);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);   // catch any stray result words

    if (err_count == 0) begin
      $display("double_ended_queue_unit: match");
    end else begin
      $display("double_ended_queue_unit: mismatch");
    end
    $finish;
  end

endmodule
